// File: design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended queue
// Request and status codes, the per-cell command and the sequencer state.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DATA_W   = 32;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 5;

    // request codes carried on s_tuser
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP_FWD   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DUMP_REV   = 3'd5;
    // spare codes: no operation, a single ok word
    localparam logic [REQ_W-1:0] REQ_SPARE_A    = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B    = 3'd7;

    // status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_ROT_FWD,
        CMD_ROT_REV
    } cell_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

endpackage

// File: design/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded deque of signed 32-bit words
// A row of DEPTH cells holds the entries, front in cell 0. Front pushes
// and pops shift the row, back ones do not; dumps rotate it one place per emitted word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tuser carries the request code, s_tdata the value
//   to push. Output channel m_*: one word per result, m_tlast marks the
//   final word of a request, m_tuser the status.
//   A result is registered and appears in the cycle after its request is accepted.
//   Push, pop and no-op requests are accepted back to back while the receiver
//   keeps up. A dump emits its entries one word per cycle while m_tready holds,
//   one rotation step of the cell row per word; s_tready stays low until the
//   last word of the dump has been loaded.
//   Reset clears the entry count, the sequencer and the output valid flag;
//   cell contents are left as they are and are never read before being written.
//   When the receiver stalls, the output word holds and the block stops
//   taking requests (and stops advancing a dump) until m_tready returns.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [31:0] push_value
    input  logic [REQ_W-1:0]    s_tuser,   // [2:0] req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [31:0] data_out, [36:32] entries_held, rest 0
    output logic [STATUS_W-1:0] m_tuser,   // [1:0] status
    output logic                m_tlast    // last_of_run
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // cell row
    logic [DATA_W-1:0] cell_q [DEPTH];
    logic [DATA_W-1:0] front_data;
    logic [DATA_W-1:0] back_data;
    logic [IW-1:0]     back_idx;
    cell_cmd_t         cmd;

    // control state
    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] left_reg;
    logic [CW-1:0] left_next;
    logic          dir_rev_reg;
    logic          dir_rev_next;

    // output word
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [HELD_W-1:0]   out_held_reg;
    logic                out_last_reg;

    logic                slot_free;
    logic                accept;
    logic                dump_start;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic [DATA_W-1:0]   emit_data;
    logic                emit_last;

    // the output register can take a word when empty or being drained
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;

    assign back_idx   = IW'(count_reg - ONE_C);
    assign front_data = cell_q[0];
    assign back_data  = cell_q[back_idx];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_in;
            logic [DATA_W-1:0] right_in;

            if (gi == 0)
            begin : g_first
                assign left_in = cell_q[0];
            end
            else
            begin : g_mid_l
                assign left_in = cell_q[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_in = cell_q[DEPTH-1];
            end
            else
            begin : g_mid_r
                assign right_in = cell_q[gi+1];
            end

            dq_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .count      (count_reg),
                .push_value (s_tdata),
                .left_data  (left_in),
                .right_data (right_in),
                .front_data (front_data),
                .back_data  (back_data),
                .data       (cell_q[gi])
            );
        end
    endgenerate

    // next state of the dump sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (dump_start)
                begin
                    state_next = S_DUMP;
                end
            end
            S_DUMP:
            begin
                if (slot_free && (left_reg == ONE_C))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // decode the request or the dump step into a row command and a result
    always_comb
    begin
        cmd          = CMD_HOLD;
        count_next   = count_reg;
        left_next    = left_reg;
        dir_rev_next = dir_rev_reg;
        dump_start   = 1'b0;
        emit         = 1'b0;
        emit_status  = STAT_OK;
        emit_data    = '0;
        emit_last    = 1'b1;
        unique case (state_reg)
            S_DUMP:
            begin
                if (slot_free)
                begin
                    // emit the current end entry and rotate it away
                    emit      = 1'b1;
                    emit_data = dir_rev_reg ? back_data : front_data;
                    cmd       = dir_rev_reg ? CMD_ROT_REV : CMD_ROT_FWD;
                    emit_last = (left_reg == ONE_C);
                    left_next = left_reg - ONE_C;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    emit = 1'b1;
                    case (s_tuser) inside
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                // drop the value, keep the state
                                emit_status = STAT_FULL;
                            end
                            else
                            begin
                                cmd = (s_tuser == REQ_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                  : CMD_PUSH_BACK;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                emit_status = STAT_EMPTY;
                            end
                            else
                            begin
                                if (s_tuser == REQ_POP_FRONT)
                                begin
                                    emit_data = front_data;
                                    cmd       = CMD_POP_FRONT;
                                end
                                else
                                begin
                                    emit_data = back_data;
                                end
                                count_next = count_reg - ONE_C;
                            end
                        end
                        REQ_DUMP_FWD, REQ_DUMP_REV:
                        begin
                            if (count_reg == '0)
                            begin
                                emit_status = STAT_EMPTY;
                            end
                            else
                            begin
                                dir_rev_next = (s_tuser == REQ_DUMP_REV);
                                emit_data    = dir_rev_next ? back_data : front_data;
                                cmd          = dir_rev_next ? CMD_ROT_REV : CMD_ROT_FWD;
                                emit_last    = (count_reg == ONE_C);
                                dump_start   = (count_reg != ONE_C);
                                left_next    = count_reg - ONE_C;
                            end
                        end
                        default:
                        begin
                            emit_status = STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                cmd = CMD_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            dir_rev_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            dir_rev_reg <= dir_rev_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload, loaded only with a new word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_data_reg   <= emit_data;
            out_held_reg   <= HELD_W'(count_next);
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_held_reg, out_data_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (count_reg != '0) && (left_reg != '0)
                                  && (left_reg < count_reg))
        else $error("dump running with bad remaining count");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted request gave no result");

    a_dump_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) ##1 (state_reg == S_IDLE) |-> m_tvalid && m_tlast)
        else $error("dump ended without a last word");

    a_dump_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> $stable(count_reg))
        else $error("entry count changed during dump");

endmodule

// File: design/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the deque row
// Holds one entry; shifts, loads or rotates it under the broadcast command.
// ----------------------------------------------------------------------------
module dq_cell
    import dq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
)
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [CW-1:0]     count,
    input  logic [DATA_W-1:0] push_value,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    input  logic [DATA_W-1:0] front_data,
    input  logic [DATA_W-1:0] back_data,
    output logic [DATA_W-1:0] data
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd)
            CMD_HOLD:
            begin
                data_next = data_reg;
            end
            CMD_PUSH_FRONT:
            begin
                data_next = (IDX == 0) ? push_value : left_data;
            end
            CMD_PUSH_BACK:
            begin
                if (count == IDX_C)
                begin
                    data_next = push_value;
                end
            end
            CMD_POP_FRONT:
            begin
                data_next = right_data;
            end
            CMD_ROT_FWD:
            begin
                // front entry wraps into the back slot
                if (IDX_P1 < count)
                begin
                    data_next = right_data;
                end
                else if (IDX_P1 == count)
                begin
                    data_next = front_data;
                end
            end
            CMD_ROT_REV:
            begin
                // back entry wraps into the front slot
                if (IDX == 0)
                begin
                    data_next = back_data;
                end
                else if (IDX_C < count)
                begin
                    data_next = left_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
